[hdl/bfa_pkg.sv]
package bfa_pkg;

    // Bitmap geometry
    localparam int MAP_BITS  = 8192;
    localparam int WORD_W    = 32;
    localparam int MAP_WORDS = (MAP_BITS + WORD_W - 1) / WORD_W;
    localparam int WADDR_W   = $clog2(MAP_WORDS);
    localparam int BIT_W     = $clog2(WORD_W);
    localparam int IDX_W     = WADDR_W + BIT_W;

    // Field widths
    localparam int FIELD_W  = 14;
    localparam int STATUS_W = 2;

    localparam logic [FIELD_W-1:0] MAP_BITS_F  = FIELD_W'(MAP_BITS);
    localparam logic [FIELD_W-1:0] LIMIT_RESET = 14'd8192;

    // Request actions
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 2'd3;

    typedef struct packed {
        logic               wr_en;
        logic [WADDR_W-1:0] wr_addr;
        logic [WORD_W-1:0]  wr_data;
        logic               rd_en;
        logic [WADDR_W-1:0] rd_addr;
    } ram_req_t;

    typedef struct packed {
        logic [FIELD_W-1:0]  granted_number;
        logic [STATUS_W-1:0] status;
        logic [FIELD_W-1:0]  free_count;
    } result_t;

endpackage

[hdl/bfa_if.sv]
interface bfa_req_if
    import bfa_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               action;
    logic [FIELD_W-1:0] item_number;

    modport source (output valid, output action, output item_number, input ready);
    modport sink   (input valid, input action, input item_number, output ready);
endinterface

interface bfa_rsp_if
    import bfa_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [FIELD_W-1:0]  granted_number;
    logic [STATUS_W-1:0] status;
    logic [FIELD_W-1:0]  free_count;

    modport source (output valid, output granted_number, output status,
                    output free_count, input ready);
    modport sink   (input valid, input granted_number, input status,
                    input free_count, output ready);
endinterface

interface bfa_cfg_if
    import bfa_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hdl/bfa_word_ram.sv]
module bfa_word_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/bfa_zero_find.sv]
module bfa_zero_find
    import bfa_pkg::*;
(
    input  logic [WORD_W-1:0] word,
    output logic              found,
    output logic [BIT_W-1:0]  pos
);

    // Pick the lowest clear bit: the last hit from the top wins
    always_comb
    begin
        found = 1'b0;
        pos   = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (!word[i])
            begin
                found = 1'b1;
                pos   = BIT_W'(i);
            end
        end
    end

endmodule

[hdl/bfa_ctrl.sv]
module bfa_ctrl
    import bfa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    bfa_req_if.sink            req,
    input  logic [FIELD_W-1:0] bits_in_use,
    output ram_req_t           ram_req,
    input  logic [WORD_W-1:0]  ram_rdata,
    output result_t            res,
    output logic               res_valid,
    input  logic               res_take
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SCAN     = 3'd1;
    localparam logic [2:0] S_FREE_CHK = 3'd2;
    localparam logic [2:0] S_DONE     = 3'd3;

    logic [2:0]           state_reg;
    logic [MAP_WORDS-1:0] word_vld_reg;
    logic [FIELD_W-1:0]   free_cnt_reg;
    logic                 chk_vld_reg;
    logic [WADDR_W-1:0]   rd_ptr_reg;
    logic [WADDR_W-1:0]   chk_ptr_reg;
    logic [WADDR_W-1:0]   last_reg;
    logic [WORD_W-1:0]    tail_mask_reg;
    logic [BIT_W-1:0]     fbit_reg;
    result_t              res_reg;

    logic [FIELD_W-1:0]   limit;
    logic [FIELD_W-1:0]   limit_m1;
    logic [BIT_W-1:0]     tail_bits;
    logic [FIELD_W-1:0]   num_m1;
    logic                 num_bad;
    logic                 accept;
    logic [WORD_W-1:0]    eff_word;
    logic [WORD_W-1:0]    scan_word;
    logic                 found;
    logic [BIT_W-1:0]     pos;
    logic [WORD_W-1:0]    pos_bit;
    logic [WORD_W-1:0]    fbit_bit;
    logic [FIELD_W-1:0]   cnt_dec;
    logic [FIELD_W-1:0]   cnt_inc;
    logic [FIELD_W-1:0]   granted;

    // Clamp the limit to the map and work out the scan bounds
    assign limit     = (int'(bits_in_use) > MAP_BITS) ? MAP_BITS_F : bits_in_use;
    assign limit_m1  = limit - 1'b1;
    assign tail_bits = limit[BIT_W-1:0];

    // Free request decode
    assign num_m1  = req.item_number - 1'b1;
    assign num_bad = (req.item_number == '0) || (int'(req.item_number) > MAP_BITS);

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;

    // A word never written since reset reads as all free
    assign eff_word  = word_vld_reg[chk_ptr_reg] ? ram_rdata : '0;
    assign scan_word = eff_word | ((chk_ptr_reg == last_reg) ? tail_mask_reg : '0);

    bfa_zero_find u_zero_find (
        .word  (scan_word),
        .found (found),
        .pos   (pos)
    );

    assign pos_bit  = WORD_W'(1) << pos;
    assign fbit_bit = WORD_W'(1) << fbit_reg;
    assign cnt_dec  = (free_cnt_reg != '0) ? free_cnt_reg - 1'b1 : free_cnt_reg;
    assign cnt_inc  = (free_cnt_reg < MAP_BITS_F) ? free_cnt_reg + 1'b1 : free_cnt_reg;
    assign granted  = FIELD_W'({chk_ptr_reg, pos}) + 1'b1;

    // Drive the bitmap memory
    always_comb
    begin
        ram_req = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && req.action == ACT_FREE && !num_bad)
                begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = num_m1[IDX_W-1:BIT_W];
                end
            end
            S_SCAN:
            begin
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = rd_ptr_reg;
                if (chk_vld_reg && found)
                begin
                    ram_req.wr_en   = 1'b1;
                    ram_req.wr_addr = chk_ptr_reg;
                    ram_req.wr_data = eff_word | pos_bit;
                end
            end
            S_FREE_CHK:
            begin
                if ((eff_word & fbit_bit) != '0)
                begin
                    ram_req.wr_en   = 1'b1;
                    ram_req.wr_addr = chk_ptr_reg;
                    ram_req.wr_data = eff_word & ~fbit_bit;
                end
            end
            S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Sequence requests, hold word flags and the free counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            word_vld_reg <= '0;
            free_cnt_reg <= MAP_BITS_F;
            chk_vld_reg  <= 1'b0;
        end
        else
        begin
            if (ram_req.wr_en)
            begin
                word_vld_reg[ram_req.wr_addr] <= 1'b1;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    chk_vld_reg <= 1'b0;
                    if (accept)
                    begin
                        if (req.action == ACT_ALLOC)
                        begin
                            state_reg <= (limit == '0) ? S_DONE : S_SCAN;
                        end
                        else
                        begin
                            state_reg <= num_bad ? S_DONE : S_FREE_CHK;
                        end
                    end
                end
                S_SCAN:
                begin
                    chk_vld_reg <= 1'b1;
                    if (chk_vld_reg && found)
                    begin
                        free_cnt_reg <= cnt_dec;
                        state_reg    <= S_DONE;
                    end
                    else if (chk_vld_reg && chk_ptr_reg == last_reg)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_FREE_CHK:
                begin
                    if ((eff_word & fbit_bit) != '0)
                    begin
                        free_cnt_reg <= cnt_inc;
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (res_take)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Scan pointers and the result under construction
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rd_ptr_reg    <= '0;
                    last_reg      <= limit_m1[IDX_W-1:BIT_W];
                    tail_mask_reg <= (tail_bits == '0) ? '0 : ({WORD_W{1'b1}} << tail_bits);
                    chk_ptr_reg   <= num_m1[IDX_W-1:BIT_W];
                    fbit_reg      <= num_m1[BIT_W-1:0];
                    res_reg.granted_number <= '0;
                    res_reg.free_count     <= free_cnt_reg;
                    if (req.action == ACT_ALLOC)
                    begin
                        res_reg.status <= ST_FULL;
                    end
                    else
                    begin
                        res_reg.status <= num_bad ? ST_RANGE : ST_OK;
                    end
                end
            end
            S_SCAN:
            begin
                chk_ptr_reg <= rd_ptr_reg;
                if (rd_ptr_reg != last_reg)
                begin
                    rd_ptr_reg <= rd_ptr_reg + 1'b1;
                end
                if (chk_vld_reg && found)
                begin
                    res_reg.granted_number <= granted;
                    res_reg.status         <= ST_OK;
                    res_reg.free_count     <= cnt_dec;
                end
            end
            S_FREE_CHK:
            begin
                if ((eff_word & fbit_bit) != '0)
                begin
                    res_reg.free_count <= cnt_inc;
                end
                else
                begin
                    res_reg.status <= ST_NOT_ALLOC;
                end
            end
            S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign res       = res_reg;
    assign res_valid = (state_reg == S_DONE);

    // The free counter stays within the map
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        free_cnt_reg <= MAP_BITS_F)
        else $error("free counter above map size");

    // The read pointer never runs past the last word of the scan
    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (rd_ptr_reg <= last_reg))
        else $error("scan pointer past last word");

    // A bitmap write during the scan ends in a granted item
    a_grant: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && ram_req.wr_en) |=>
            (state_reg == S_DONE && res_reg.status == ST_OK && res_reg.granted_number != '0))
        else $error("scan write without grant");

    // The counter moves only with a bitmap write
    a_cnt_write: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(free_cnt_reg) |-> $past(ram_req.wr_en))
        else $error("free counter changed without bitmap write");

endmodule

[hdl/bitmap_first_free_allocator.sv]
// Channel  Dir  Handshake        Item
// req      in   valid / ready    action, item_number
// rsp      out  valid / ready    granted_number, status, free_count
// cfg      in   valid / ready    data -> bits_in_use
//
// Allocate reads k words before its result, k being the number of
// 32-bit bitmap words scanned (1 to 256): one word per cycle through the
// single read port of the bitmap memory. Free checks one bitmap word; a
// rejected or trivially full request goes straight to its result.
// Reset clears one flag per memory word, so the bitmap reads as all free at once.
// A result waits in the output register; the next item is accepted meanwhile.
module bitmap_first_free_allocator
    import bfa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    bfa_req_if.sink   req,
    bfa_rsp_if.source rsp,
    bfa_cfg_if.sink   cfg
);

    logic [FIELD_W-1:0] bits_in_use_reg;
    logic               out_valid_reg;
    result_t            out_reg;

    ram_req_t           ram_req;
    logic [WORD_W-1:0]  ram_rdata;
    result_t            res;
    logic               res_valid;
    logic               res_take;

    // Limit register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_in_use_reg <= LIMIT_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            bits_in_use_reg <= cfg.data;
        end
    end

    bfa_word_ram #(
        .DEPTH (MAP_WORDS),
        .WIDTH (WORD_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_req.wr_en),
        .wr_addr (ram_req.wr_addr),
        .wr_data (ram_req.wr_data),
        .rd_en   (ram_req.rd_en),
        .rd_addr (ram_req.rd_addr),
        .rd_data (ram_rdata)
    );

    bfa_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .bits_in_use (bits_in_use_reg),
        .ram_req     (ram_req),
        .ram_rdata   (ram_rdata),
        .res         (res),
        .res_valid   (res_valid),
        .res_take    (res_take)
    );

    // Output register: load when empty or being drained
    assign res_take = res_valid && (!out_valid_reg || rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= res;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.granted_number = out_reg.granted_number;
    assign rsp.status         = out_reg.status;
    assign rsp.free_count     = out_reg.free_count;

endmodule

[tb/sv/bfa_alloc_scoreboard_pkg.sv]
`timescale 1ns / 100ps

package bfa_alloc_scoreboard_pkg;

    import bfa_pkg::*;

    class alloc_scoreboard;

        bit          in_use [MAP_BITS];
        int unsigned free_left;
        int unsigned alloc_limit;
        result_t     answers_due [$];
        int unsigned held [$];
        int unsigned mismatches;
        int unsigned n_requests;
        int unsigned n_granted;
        int unsigned n_full;
        int unsigned n_range;
        int unsigned n_not_alloc;
        int unsigned n_released;

        function new();
            foreach (in_use[i])
                in_use[i] = 1'b0;
            free_left   = MAP_BITS;
            alloc_limit = LIMIT_RESET;
            mismatches  = 0;
            n_requests  = 0;
            n_granted   = 0;
            n_full      = 0;
            n_range     = 0;
            n_not_alloc = 0;
            n_released  = 0;
        endfunction

        function void set_limit(logic [FIELD_W-1:0] value);
            alloc_limit = value;
        endfunction

        // Work out the answer to one accepted request and queue it
        function void note_request(logic act, logic [FIELD_W-1:0] num);
            result_t     answer;
            int unsigned span;
            answer.granted_number = '0;
            answer.status         = ST_OK;
            n_requests++;
            if (act == ACT_ALLOC)
            begin
                // saturate the limit to the map size, then take the lowest free entry
                span          = (alloc_limit > MAP_BITS) ? MAP_BITS : alloc_limit;
                answer.status = ST_FULL;
                for (int i = 0; i < span; i++)
                begin
                    if (!in_use[i])
                    begin
                        in_use[i] = 1'b1;
                        if (free_left > 0)
                            free_left--;
                        answer.granted_number = FIELD_W'(i + 1);
                        answer.status         = ST_OK;
                        held.push_back(i + 1);
                        break;
                    end
                end
                if (answer.status == ST_OK)
                    n_granted++;
                else
                    n_full++;
            end
            else
            begin
                if (num == 0 || num > MAP_BITS)
                begin
                    answer.status = ST_RANGE;
                    n_range++;
                end
                else if (!in_use[num - 1])
                begin
                    answer.status = ST_NOT_ALLOC;
                    n_not_alloc++;
                end
                else
                begin
                    in_use[num - 1] = 1'b0;
                    if (free_left < MAP_BITS)
                        free_left++;
                    n_released++;
                    for (int k = 0; k < held.size(); k++)
                    begin
                        if (held[k] == num)
                        begin
                            held.delete(k);
                            break;
                        end
                    end
                end
            end
            answer.free_count = FIELD_W'(free_left);
            answers_due.push_back(answer);
        endfunction

        // Compare one accepted result with the oldest answer due
        function void check_result(result_t got);
            result_t want;
            if (answers_due.size() == 0)
            begin
                $display("%0t: result with no answer due: granted %0d status %0d free_count %0d",
                         $time, got.granted_number, got.status, got.free_count);
                mismatches++;
                return;
            end
            want = answers_due.pop_front();
            if (got.granted_number !== want.granted_number)
            begin
                $display("%0t: granted_number mismatch: expected %0d, actual %0d",
                         $time, want.granted_number, got.granted_number);
                mismatches++;
            end
            if (got.status !== want.status)
            begin
                $display("%0t: status mismatch: expected %0d, actual %0d",
                         $time, want.status, got.status);
                mismatches++;
            end
            if (got.free_count !== want.free_count)
            begin
                $display("%0t: free_count mismatch: expected %0d, actual %0d",
                         $time, want.free_count, got.free_count);
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return answers_due.size();
        endfunction

        // Any entry believed to be allocated, or 0 when none is
        function int unsigned pick_held();
            if (held.size() == 0)
                return 0;
            return held[$urandom_range(0, held.size() - 1)];
        endfunction

    endclass

endpackage

[tb/sv/bitmap_first_free_allocator_test.sv]
`timescale 1ns / 100ps

module bitmap_first_free_allocator_test;

    import bfa_pkg::*;
    import bfa_alloc_scoreboard_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int STALL_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 300;
    localparam int PHASE_ITEMS  = 154;
    localparam int NUM_PHASES   = 12;
    localparam int FIELD_MAX    = (1 << FIELD_W) - 1;

    logic clk;
    logic rst_n;

    bfa_req_if req_ch ();
    bfa_rsp_if rsp_ch ();
    bfa_cfg_if cfg_ch ();

    alloc_scoreboard sb;

    bit          steady;
    bit          hold_rsp;
    bit          hold_active;
    int unsigned idle_cycles;
    int unsigned cfg_writes;

    bitmap_first_free_allocator u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Gap before the next item: mostly none, sometimes short, rarely long
    function automatic int unsigned sender_gap();
        int unsigned r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one item, hold it until accepted, then note it
    task automatic send_request(input logic act, input logic [FIELD_W-1:0] num);
        int unsigned gap;
        req_ch.valid       <= 1'b1;
        req_ch.action      <= act;
        req_ch.item_number <= num;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        sb.note_request(act, num);
        gap = sender_gap();
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid and wait until every answer due has come back
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [FIELD_W-1:0] value);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        sb.set_limit(value);
        cfg_writes++;
        @(posedge clk);
    endtask

    task automatic run_directed();
        // Reset limit: grant, release, double release and out-of-range numbers
        send_request(ACT_ALLOC, '0);
        send_request(ACT_ALLOC, '0);
        send_request(ACT_FREE, 14'd1);
        send_request(ACT_FREE, 14'd1);
        send_request(ACT_FREE, 14'd0);
        send_request(ACT_FREE, FIELD_W'(MAP_BITS + 1));
        send_request(ACT_FREE, FIELD_W'(FIELD_MAX));
        send_request(ACT_FREE, MAP_BITS_F);
        send_request(ACT_ALLOC, FIELD_W'(FIELD_MAX));
        // Limit of one with entry 1 taken: map full, entry 2 still releasable
        write_limit(14'd1);
        send_request(ACT_ALLOC, '0);
        send_request(ACT_FREE, 14'd2);
        send_request(ACT_ALLOC, '0);
        // Limit of zero never grants
        write_limit(14'd0);
        send_request(ACT_ALLOC, '0);
        send_request(ACT_FREE, 14'd1);
        send_request(ACT_ALLOC, '0);
        // Limit above the map saturates
        write_limit(FIELD_W'(FIELD_MAX));
        send_request(ACT_ALLOC, '0);
        send_request(ACT_ALLOC, '0);
        write_limit(14'd3);
        send_request(ACT_ALLOC, '0);
        send_request(ACT_FREE, 14'd3);
        send_request(ACT_ALLOC, '0);
        send_request(ACT_ALLOC, '0);
        write_limit(MAP_BITS_F);
        send_request(ACT_FREE, 14'd2);
        send_request(ACT_ALLOC, '0);
    endtask

    // One random item: mostly grants and releases of held entries, some noise
    task automatic random_item(input int unsigned cap);
        int unsigned r;
        int unsigned alloc_share;
        int unsigned pick;
        r           = $urandom_range(0, 99);
        alloc_share = (sb.held.size() < cap) ? 55 : 40;
        if (r < 10)
        begin
            pick = $urandom_range(0, 4);
            case (pick)
                0:       send_request(ACT_FREE, 14'd0);
                1:       send_request(ACT_FREE, FIELD_W'($urandom_range(MAP_BITS + 1, FIELD_MAX)));
                2:       send_request(ACT_FREE, MAP_BITS_F);
                default: send_request(ACT_FREE, FIELD_W'($urandom_range(1, MAP_BITS)));
            endcase
        end
        else if (r < 10 + alloc_share || sb.held.size() == 0)
        begin
            send_request(ACT_ALLOC, FIELD_W'($urandom_range(0, FIELD_MAX)));
        end
        else
        begin
            send_request(ACT_FREE, FIELD_W'(sb.pick_held()));
        end
    endtask

    task automatic run_random();
        int unsigned phase_limits [NUM_PHASES];
        int unsigned span;
        int unsigned cap;
        phase_limits = '{MAP_BITS, 5, FIELD_MAX, 32, 1, 100, MAP_BITS - 1, 64, 0, 17,
                         2000, 40};
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_limit(FIELD_W'(phase_limits[p]));
            span   = (phase_limits[p] > MAP_BITS) ? MAP_BITS : phase_limits[p];
            cap    = (span < 200) ? span : 200;
            steady = (p == 2 || p == 7);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                // Stall the result side long enough for the block to back up
                if (p == 3 && k == PHASE_ITEMS / 3)
                begin
                    req_ch.valid <= 1'b0;
                    hold_rsp = 1'b1;
                    wait (hold_active);
                    @(posedge clk);
                    steady = 1'b1;
                    repeat (12) random_item(cap);
                    steady = 1'b0;
                end
                // Pause the request side until everything has come back
                if (p == 5 && k == PHASE_ITEMS / 2)
                    wait_drained();
                random_item(cap);
            end
        end
        steady = 1'b0;
    endtask

    // Result side: random ready pattern, one long hold on request
    initial
    begin
        int unsigned r;
        rsp_ch.ready <= 1'b0;
        hold_active = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_rsp)
            begin
                hold_rsp     = 1'b0;
                hold_active  = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_active  = 1'b0;
            end
            else if (steady)
            begin
                rsp_ch.ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 65)
                begin
                    rsp_ch.ready <= 1'b1;
                    repeat ($urandom_range(1, 8)) @(posedge clk);
                end
                else if (r < 95)
                begin
                    rsp_ch.ready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge clk);
                end
                else
                begin
                    rsp_ch.ready <= 1'b0;
                    repeat ($urandom_range(20, 60)) @(posedge clk);
                end
            end
        end
    end

    // Check results and watch for a stuck handshake
    always @(posedge clk)
    begin : bus_monitor
        result_t seen;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                seen.granted_number = rsp_ch.granted_number;
                seen.status         = rsp_ch.status;
                seen.free_count     = rsp_ch.free_count;
                sb.check_result(seen);
            end
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no item moved for %0d cycles, %0d answers still due",
                         $time, idle_cycles, sb.pending());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        sb          = new();
        steady      = 1'b0;
        hold_rsp    = 1'b0;
        idle_cycles = 0;
        cfg_writes  = 0;

        rst_n              <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.action      <= ACT_ALLOC;
        req_ch.item_number <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.data        <= '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random();

        // Drain, then allow for the longest scan before judging
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d requests over %0d limit writes: %0d granted, %0d full, %0d released",
                 sb.n_requests, cfg_writes, sb.n_granted, sb.n_full, sb.n_released);
        $display("Rejected frees: %0d out of range, %0d of entries not allocated",
                 sb.n_range, sb.n_not_alloc);
        if (sb.mismatches == 0 && sb.pending() == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("%0d mismatches, %0d answers never arrived", sb.mismatches, sb.pending());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
